// File: src/oriented_rect_overlap_test_top_macros.svh
// Assertion macros shared by the overlap test RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ORIENTED_RECT_OVERLAP_TEST_TOP_MACROS_SVH
`define ORIENTED_RECT_OVERLAP_TEST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ORT_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ORT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ORT_ASSERT_HOLDS(label, cond, msg)
`define ORT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/ort_pkg.sv
// Package for the oriented rectangle overlap test: widths, CORDIC table,
// job word width. No dependencies.
`timescale 1ns / 1ps
package ort_pkg;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int COORD_W        = 24;
    localparam int SIZE_W         = 16;
    localparam int HEAD_W         = 16;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int CORDIC_STEPS   = 24;
    localparam int CORDIC_W       = 33;
    localparam int QUEUE_DEPTH    = 4;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

    // atan(2^-i) in turns times 2^32
    localparam logic [31:0] ORT_ATAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // job word: dx, dy, four sizes, four trig values
    function automatic int ort_job_w(input int trig_frac);
        return 2 * DIFF_W + 4 * SIZE_W + 4 * (trig_frac + 2);
    endfunction
endpackage

// File: src/ort_ifs.sv
// Channel interfaces: rectangle pair in, overlap verdict out.
// Depends on ort_pkg.
`timescale 1ns / 1ps
interface ort_pair_if
    import ort_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] a_center_x;
    logic signed [COORD_W-1:0] a_center_y;
    logic [SIZE_W-1:0]         a_length;
    logic [SIZE_W-1:0]         a_width;
    logic [HEAD_W-1:0]         a_heading;
    logic signed [COORD_W-1:0] b_center_x;
    logic signed [COORD_W-1:0] b_center_y;
    logic [SIZE_W-1:0]         b_length;
    logic [SIZE_W-1:0]         b_width;
    logic [HEAD_W-1:0]         b_heading;

    modport source (
        output valid, a_center_x, a_center_y, a_length, a_width, a_heading,
               b_center_x, b_center_y, b_length, b_width, b_heading,
        input  ready
    );
    modport sink (
        input  valid, a_center_x, a_center_y, a_length, a_width, a_heading,
               b_center_x, b_center_y, b_length, b_width, b_heading,
        output ready
    );
endinterface

interface ort_result_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface

// File: src/ort_front.sv
// Front end: takes pair items, runs both headings through a pipelined
// CORDIC, emits job words. Depends on ort_pkg, ort_ifs.
`timescale 1ns / 1ps
module ort_front
    import ort_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = ort_pkg::TRIG_FRAC_BITS,
    parameter int JOB_W          = ort_job_w(ort_pkg::TRIG_FRAC_BITS)
) (
    input  logic             clk,
    input  logic             rst_n,
    ort_pair_if.sink         pairs,
    output logic             job_valid,
    input  logic             job_ready,
    output logic [JOB_W-1:0] job_data
);
    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int CW     = CORDIC_W;
    localparam int NS     = CORDIC_STEPS;
    localparam int NF     = NS + 2;
    localparam int SH     = 30 - TRIG_FRAC_BITS;
    localparam int SIDE_W = 2 * DIFF_W + 4 * SIZE_W + 6;
    localparam logic signed [CW-1:0] RND = CW'(1) <<< (SH - 1);
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< TRIG_FRAC_BITS;

    logic [NF-1:0]            vld_reg;
    logic                     en;
    logic                     accept;
    logic signed [CW-1:0]     x_reg [0:NS][0:1];
    logic signed [CW-1:0]     y_reg [0:NS][0:1];
    logic signed [CW-1:0]     z_reg [0:NS][0:1];
    logic [SIDE_W-1:0]        side_reg [0:NS];
    logic signed [TW-1:0]     c_reg [0:1];
    logic signed [TW-1:0]     s_reg [0:1];
    logic [SIDE_W-7:0]        keep_reg;

    logic [HEAD_W-1:0]        head [0:1];
    logic [HEAD_W-1:0]        qsum [0:1];
    logic [1:0]               quad [0:1];
    logic signed [HEAD_W-1:0] resid [0:1];
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [CW-1:0]     xr [0:1];
    logic signed [CW-1:0]     yr [0:1];
    logic signed [TW-1:0]     cs [0:1];
    logic signed [TW-1:0]     sn [0:1];
    logic signed [TW-1:0]     c_next [0:1];
    logic signed [TW-1:0]     s_next [0:1];
    logic [1:0]               fq [0:1];
    logic                     frz [0:1];

    assign en          = !vld_reg[NF-1] || job_ready;
    assign pairs.ready = en;
    assign accept      = pairs.valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NF-2:0], accept};
        end
    end

    // split each heading into a quadrant and a residual in [-1/8, 1/8) turn
    always_comb
    begin
        head[0] = pairs.a_heading;
        head[1] = pairs.b_heading;
        for (int j = 0; j < 2; j++)
        begin
            qsum[j]  = head[j] + 16'd8192;
            quad[j]  = qsum[j][15:14];
            resid[j] = signed'(head[j] - {quad[j], 14'd0});
        end
        dx = DIFF_W'(pairs.b_center_x) - DIFF_W'(pairs.a_center_x);
        dy = DIFF_W'(pairs.b_center_y) - DIFF_W'(pairs.a_center_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 2; j++)
            begin
                x_reg[0][j] <= CORDIC_X0;
                y_reg[0][j] <= '0;
                z_reg[0][j] <= {{(CW-32){resid[j][15]}}, resid[j], 16'd0};
            end
            side_reg[0] <= {dx, dy, pairs.a_length, pairs.a_width,
                            pairs.b_length, pairs.b_width, quad[0], quad[1],
                            resid[0] == '0, resid[1] == '0};
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        localparam logic signed [CW-1:0] ANG = {1'b0, ORT_ATAN[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    if (!z_reg[i][j][CW-1])
                    begin
                        x_reg[i+1][j] <= x_reg[i][j] - (y_reg[i][j] >>> i);
                        y_reg[i+1][j] <= y_reg[i][j] + (x_reg[i][j] >>> i);
                        z_reg[i+1][j] <= z_reg[i][j] - ANG;
                    end
                    else
                    begin
                        x_reg[i+1][j] <= x_reg[i][j] + (y_reg[i][j] >>> i);
                        y_reg[i+1][j] <= y_reg[i][j] - (x_reg[i][j] >>> i);
                        z_reg[i+1][j] <= z_reg[i][j] + ANG;
                    end
                end
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // round, saturate, exact zero residual, then quarter-turn rotation
    always_comb
    begin
        fq[0]  = side_reg[NS][5:4];
        fq[1]  = side_reg[NS][3:2];
        frz[0] = side_reg[NS][1];
        frz[1] = side_reg[NS][0];
        for (int j = 0; j < 2; j++)
        begin
            xr[j] = (x_reg[NS][j] + RND) >>> SH;
            yr[j] = (y_reg[NS][j] + RND) >>> SH;
            if (xr[j] > ONE)
                xr[j] = ONE;
            if (xr[j] < -ONE)
                xr[j] = -ONE;
            if (yr[j] > ONE)
                yr[j] = ONE;
            if (yr[j] < -ONE)
                yr[j] = -ONE;
            cs[j] = frz[j] ? TW'(ONE) : TW'(xr[j]);
            sn[j] = frz[j] ? '0 : TW'(yr[j]);
            case (fq[j])
                2'd1:
                begin
                    c_next[j] = -sn[j];
                    s_next[j] = cs[j];
                end
                2'd2:
                begin
                    c_next[j] = -cs[j];
                    s_next[j] = -sn[j];
                end
                2'd3:
                begin
                    c_next[j] = sn[j];
                    s_next[j] = -cs[j];
                end
                default:
                begin
                    c_next[j] = cs[j];
                    s_next[j] = sn[j];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 2; j++)
            begin
                c_reg[j] <= c_next[j];
                s_reg[j] <= s_next[j];
            end
            keep_reg <= side_reg[NS][SIDE_W-1:6];
        end
    end

    assign job_valid = vld_reg[NF-1];
    assign job_data  = {keep_reg, c_reg[0], s_reg[0], c_reg[1], s_reg[1]};
endmodule

// File: src/ort_queue.sv
// Short job queue between front and back end.
// Depends on the macros header.
`timescale 1ns / 1ps
`include "oriented_rect_overlap_test_top_macros.svh"
module ort_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (PW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `ORT_ASSERT_HOLDS(a_cnt_bound, cnt_reg <= (PW+1)'(DEPTH), "queue count over depth")
    `ORT_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "count up")
    `ORT_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "count down")
endmodule

// File: src/ort_back.sv
// Back end: four axis lanes project center offset and extents, then
// combine separations into the verdict. Depends on ort_pkg, ort_ifs, macros.
`timescale 1ns / 1ps
`include "oriented_rect_overlap_test_top_macros.svh"
module ort_back
    import ort_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = ort_pkg::TRIG_FRAC_BITS,
    parameter int JOB_W          = ort_job_w(ort_pkg::TRIG_FRAC_BITS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [JOB_W-1:0] job_data,
    ort_result_if.source     verdict
);
    localparam int T    = TRIG_FRAC_BITS;
    localparam int TW   = T + 2;
    localparam int PW   = 2 * TW;
    localparam int DPW  = DIFF_W + TW;
    localparam int DSW  = DPW + 1;
    localparam int LW   = DSW + 1;
    localparam int AW   = 2 * T + 2;
    localparam int H    = T + 1;
    localparam int HPW  = SIZE_W + H;
    localparam int TMW  = SIZE_W + AW;
    localparam int SUMW = TMW + 2;
    localparam int NB   = 6;

    logic [NB-1:0]            vld_reg;
    logic                     en;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [SIZE_W-1:0]        al, aw, bl, bw;
    logic signed [TW-1:0]     ca, sa, cb, sb;
    logic signed [TW-1:0]     ux [0:3];
    logic signed [TW-1:0]     uy [0:3];
    logic                     use_ax [0:3];
    logic [4*SIZE_W-1:0]      sz1_reg, sz2_reg;

    logic signed [DPW-1:0]    mdx_reg [0:3];
    logic signed [DPW-1:0]    mdy_reg [0:3];
    logic signed [PW-1:0]     m_reg [0:3][0:7];
    logic                     ok_reg [0:3][1:4];
    logic [LW-1:0]            lhs_reg [0:3][2:4];
    logic [AW-1:0]            ab_reg [0:3][0:3];
    logic [HPW-1:0]           ph_reg [0:3][0:3];
    logic [HPW-1:0]           pl_reg [0:3][0:3];
    logic [TMW:0]             pr_reg [0:3][0:1];
    logic                     sep_reg [0:3];
    logic                     overlap_reg;

    assign {dx, dy, al, aw, bl, bw, ca, sa, cb, sb} = job_data;
    assign en        = !vld_reg[NB-1] || verdict.ready;
    assign job_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NB-2:0], job_valid};
    end

    // axes: normals of both edge pairs; a zero size edge drops its normal
    always_comb
    begin
        ux[0] = ca;  uy[0] = sa;  use_ax[0] = aw != '0;
        ux[1] = sa;  uy[1] = -ca; use_ax[1] = al != '0;
        ux[2] = cb;  uy[2] = sb;  use_ax[2] = bw != '0;
        ux[3] = sb;  uy[3] = -cb; use_ax[3] = bl != '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sz1_reg <= {al, aw, bl, bw};
            sz2_reg <= sz1_reg;
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic signed [DSW-1:0]  dd;
        logic [DSW-1:0]         dd_abs;
        logic signed [PW:0]     pj [0:3];
        logic [PW:0]            pj_abs [0:3];
        logic [SIZE_W-1:0]      szk [0:3];
        logic [TMW-1:0]         term [0:3];
        logic [SUMW-1:0]        tot;
        logic [LW-1:0]          rhs;

        always_comb
        begin
            dd     = DSW'(mdx_reg[k]) + DSW'(mdy_reg[k]);
            dd_abs = dd[DSW-1] ? DSW'(-dd) : DSW'(dd);
            // A extent terms: |e1.u|, |e2.u|; then B
            pj[0] = (PW+1)'(m_reg[k][0]) + (PW+1)'(m_reg[k][1]);
            pj[1] = (PW+1)'(m_reg[k][2]) - (PW+1)'(m_reg[k][3]);
            pj[2] = (PW+1)'(m_reg[k][4]) + (PW+1)'(m_reg[k][5]);
            pj[3] = (PW+1)'(m_reg[k][6]) - (PW+1)'(m_reg[k][7]);
            for (int j = 0; j < 4; j++)
                pj_abs[j] = pj[j][PW] ? (PW+1)'(-pj[j]) : (PW+1)'(pj[j]);
            {szk[0], szk[1], szk[2], szk[3]} = sz2_reg;
            for (int j = 0; j < 4; j++)
                term[j] = (TMW'(ph_reg[k][j]) << H) + TMW'(pl_reg[k][j]);
            tot = SUMW'(pr_reg[k][0]) + SUMW'(pr_reg[k][1]);
            rhs = LW'(tot >> T);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mdx_reg[k]   <= DPW'(dx * ux[k]);
                mdy_reg[k]   <= DPW'(dy * uy[k]);
                m_reg[k][0]  <= PW'(ca * ux[k]);
                m_reg[k][1]  <= PW'(sa * uy[k]);
                m_reg[k][2]  <= PW'(ca * uy[k]);
                m_reg[k][3]  <= PW'(sa * ux[k]);
                m_reg[k][4]  <= PW'(cb * ux[k]);
                m_reg[k][5]  <= PW'(sb * uy[k]);
                m_reg[k][6]  <= PW'(cb * uy[k]);
                m_reg[k][7]  <= PW'(sb * ux[k]);
                ok_reg[k][1] <= use_ax[k] && (ux[k] != '0 || uy[k] != '0);

                lhs_reg[k][2] <= {dd_abs, 1'b0};
                for (int j = 0; j < 4; j++)
                    ab_reg[k][j] <= pj_abs[j][AW-1:0];
                ok_reg[k][2] <= ok_reg[k][1];

                // size times magnitude, split in two narrow products
                for (int j = 0; j < 4; j++)
                begin
                    ph_reg[k][j] <= HPW'(szk[j] * ab_reg[k][j][AW-1:H]);
                    pl_reg[k][j] <= HPW'(szk[j] * ab_reg[k][j][H-1:0]);
                end
                lhs_reg[k][3] <= lhs_reg[k][2];
                ok_reg[k][3]  <= ok_reg[k][2];

                pr_reg[k][0]  <= (TMW+1)'(term[0]) + (TMW+1)'(term[1]);
                pr_reg[k][1]  <= (TMW+1)'(term[2]) + (TMW+1)'(term[3]);
                lhs_reg[k][4] <= lhs_reg[k][3];
                ok_reg[k][4]  <= ok_reg[k][3];

                sep_reg[k]    <= ok_reg[k][4] && (lhs_reg[k][4] > rhs);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            overlap_reg <= !(sep_reg[0] || sep_reg[1] || sep_reg[2] || sep_reg[3]);
    end

    assign verdict.valid   = vld_reg[NB-1];
    assign verdict.overlap = overlap_reg;

    `ORT_ASSERT_NEXT(a_hold, vld_reg[NB-1] && !verdict.ready,
                     vld_reg[NB-1] && $stable(overlap_reg), "stalled verdict changed")
    `ORT_ASSERT_NEXT(a_fill, job_valid && job_ready, vld_reg[0], "job lost on entry")
endmodule

// File: src/oriented_rect_overlap_test_top.sv
// Top level of the oriented rectangle overlap test.
// Depends on ort_pkg, ort_ifs, ort_front, ort_queue, ort_back.
`timescale 1ns / 1ps
// Separating axis test for two oriented rectangles. One pair item in, one
// overlap bit out (1 = overlap or touching). Throughput is one item per
// clock with no stalls. The front end has an input register, 24 CORDIC
// iterations per heading as pipeline stages, and a round/rotate stage;
// items then pass the job queue, and the back end has stages for axis
// products, dot sums, size products, extent sums, compare, combine. A
// 4-item queue between front and back lets a stalled result sink hold the
// back end while the front keeps taking items until the queue fills. The
// block holds no state between items; no clearing pass after reset.
// TRIG_FRAC_BITS sets the fraction bits of cosine and sine (10 to 20).
module oriented_rect_overlap_test_top
    import ort_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = ort_pkg::TRIG_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    ort_pair_if.sink     pairs,
    ort_result_if.source verdict
);
    localparam int JOB_W = ort_job_w(TRIG_FRAC_BITS);

    logic             fj_valid, fj_ready;
    logic [JOB_W-1:0] fj_data;
    logic             bj_valid, bj_ready;
    logic [JOB_W-1:0] bj_data;

    // front: headings to cosine/sine, center offset
    ort_front #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .JOB_W          (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pairs     (pairs),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    ort_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fj_valid),
        .in_ready  (fj_ready),
        .in_data   (fj_data),
        .out_valid (bj_valid),
        .out_ready (bj_ready),
        .out_data  (bj_data)
    );

    // back: four axis tests in parallel lanes
    ort_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .JOB_W          (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_data  (bj_data),
        .verdict   (verdict)
    );
endmodule

// File: sim/oriented_rect_overlap_test_top_tb.sv
// Self-checking testbench for the oriented rectangle overlap test block.
// Needs ort_pkg, ort_ifs and the RTL of oriented_rect_overlap_test_top.
`timescale 1ns / 1ps
module oriented_rect_overlap_test_top_tb;
    import ort_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] a_center_x;
        logic signed [COORD_W-1:0] a_center_y;
        logic [SIZE_W-1:0]         a_length;
        logic [SIZE_W-1:0]         a_width;
        logic [HEAD_W-1:0]         a_heading;
        logic signed [COORD_W-1:0] b_center_x;
        logic signed [COORD_W-1:0] b_center_y;
        logic [SIZE_W-1:0]         b_length;
        logic [SIZE_W-1:0]         b_width;
        logic [HEAD_W-1:0]         b_heading;
    } rect_pair_t;

    // Directed row: want is 0 or 1 when the answer is plain, -1 to ask the predictor.
    typedef struct {
        rect_pair_t pair;
        int         want;
    } pair_row_t;

    localparam int NUM_RANDOM = 950;
    localparam int NUM_ROWS   = 16;
    localparam int DRAIN_CYC  = 60;

    logic clk;
    logic rst_n;

    ort_pair_if   pair_ch ();
    ort_result_if verdict_ch ();

    oriented_rect_overlap_test_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pair_ch),
        .verdict (verdict_ch)
    );

    bit        overlap_due[$];  // expected overlap bits, oldest first
    int        error_count;
    int        send_idle_pct;   // chance in 100 that the sender idles instead of offering
    int        sink_stall_pct;  // chance in 100 that the sink drops ready
    pair_row_t rows [NUM_ROWS];

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: CORDIC heading to (cos, sin), then the edge normals of both
    // rectangles as candidate axes, with exact integer interval comparison.
    // ------------------------------------------------------------------
    function automatic void heading_cos_sin(input logic [HEAD_W-1:0] h,
                                            output longint c, output longint s);
        longint q;
        longint r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        longint one;
        one = longint'(1) <<< TRIG_FRAC_BITS;
        q = ((longint'(h) + 8192) >>> 14) & 3;
        r = longint'(h) - q * 16384;
        if (r > 32767)
            r = r - 65536;
        if (r == 0)
        begin
            c = one;
            s = 0;
        end
        else
        begin
            x = 652032874;
            y = 0;
            z = r * 65536;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ORT_ATAN[i]);
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ORT_ATAN[i]);
                end
            end
            // round to the trig format, then clamp to +/- 1.0
            c = (x + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            s = (y + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            if (c > one) c = one;
            if (c < -one) c = -one;
            if (s > one) s = one;
            if (s < -one) s = -one;
        end
        case (q)
            1:
            begin
                t = c; c = -s; s = t;
            end
            2:
            begin
                c = -c; s = -s;
            end
            3:
            begin
                t = c; c = s; s = -t;
            end
            default: ;
        endcase
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // doubled half extent of one rectangle along axis (ux, uy)
    function automatic longint span_on_axis(input longint len, input longint wid,
                                            input longint c, input longint s,
                                            input longint ux, input longint uy);
        return len * mag(c * ux + s * uy) + wid * mag(c * uy - s * ux);
    endfunction

    function automatic bit predict_overlap(input rect_pair_t p);
        longint ca, sa, cb, sb, dx, dy, ux, uy, gap, reach;
        longint al, aw, bl, bw;
        longint axis_x [4];
        longint axis_y [4];
        bit     live [4];
        heading_cos_sin(p.a_heading, ca, sa);
        heading_cos_sin(p.b_heading, cb, sb);
        al = longint'(p.a_length);
        aw = longint'(p.a_width);
        bl = longint'(p.b_length);
        bw = longint'(p.b_width);
        dx = longint'(p.b_center_x) - longint'(p.a_center_x);
        dy = longint'(p.b_center_y) - longint'(p.a_center_y);
        axis_x[0] = ca; axis_y[0] = sa;  live[0] = (aw != 0);
        axis_x[1] = sa; axis_y[1] = -ca; live[1] = (al != 0);
        axis_x[2] = cb; axis_y[2] = sb;  live[2] = (bw != 0);
        axis_x[3] = sb; axis_y[3] = -cb; live[3] = (bl != 0);
        for (int k = 0; k < 4; k++)
        begin
            ux = axis_x[k];
            uy = axis_y[k];
            // zero-size edges give no axis
            if (live[k] && !(ux == 0 && uy == 0))
            begin
                gap   = 2 * mag(dx * ux + dy * uy);
                reach = (span_on_axis(al, aw, ca, sa, ux, uy)
                       + span_on_axis(bl, bw, cb, sb, ux, uy)) >>> TRIG_FRAC_BITS;
                if (gap > reach)
                    return 1'b0;   // separating axis found
            end
        end
        return 1'b1;               // touching counts as overlap
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic pair_row_t row(input int ax, input int ay, input int al,
                                      input int aw, input int ah, input int bx,
                                      input int by, input int bl, input int bw,
                                      input int bh, input int want);
        pair_row_t r;
        r.pair.a_center_x = COORD_W'(ax);
        r.pair.a_center_y = COORD_W'(ay);
        r.pair.a_length   = SIZE_W'(al);
        r.pair.a_width    = SIZE_W'(aw);
        r.pair.a_heading  = HEAD_W'(ah);
        r.pair.b_center_x = COORD_W'(bx);
        r.pair.b_center_y = COORD_W'(by);
        r.pair.b_length   = SIZE_W'(bl);
        r.pair.b_width    = SIZE_W'(bw);
        r.pair.b_heading  = HEAD_W'(bh);
        r.want            = want;
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        // zero sizes now and then so axes get skipped
        if ($urandom_range(9) == 0)
            return '0;
        return SIZE_W'($urandom_range(65535));
    endfunction

    function automatic rect_pair_t rand_pair();
        rect_pair_t p;
        p.a_center_x = COORD_W'($urandom);
        p.a_center_y = COORD_W'($urandom);
        p.a_length   = rand_size();
        p.a_width    = rand_size();
        p.a_heading  = HEAD_W'($urandom);
        p.b_length   = rand_size();
        p.b_width    = rand_size();
        p.b_heading  = HEAD_W'($urandom);
        if ($urandom_range(99) < 80)
        begin
            // near pairs: offset on the order of the sizes, so both answers occur
            p.b_center_x = p.a_center_x + COORD_W'($urandom_range(80000) - 40000);
            p.b_center_y = p.a_center_y + COORD_W'($urandom_range(80000) - 40000);
        end
        else
        begin
            p.b_center_x = COORD_W'($urandom);
            p.b_center_y = COORD_W'($urandom);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        error_count++;
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_pair(input rect_pair_t p, input int want);
        bit due_bit;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid      <= 1'b1;
        pair_ch.a_center_x <= p.a_center_x;
        pair_ch.a_center_y <= p.a_center_y;
        pair_ch.a_length   <= p.a_length;
        pair_ch.a_width    <= p.a_width;
        pair_ch.a_heading  <= p.a_heading;
        pair_ch.b_center_x <= p.b_center_x;
        pair_ch.b_center_y <= p.b_center_y;
        pair_ch.b_length   <= p.b_length;
        pair_ch.b_width    <= p.b_width;
        pair_ch.b_heading  <= p.b_heading;
        do
            @(posedge clk);
        while (!pair_ch.ready);
        if (want >= 0 && bit'(want) != predict_overlap(p))
            $display("note: directed row disagrees with predictor");
        due_bit = (want >= 0) ? bit'(want) : predict_overlap(p);
        overlap_due.insert(overlap_due.size(), due_bit);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, check every accepted item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (overlap_due.size() == 0)
                report_mismatch("unexpected result", -1, int'(verdict_ch.overlap));
            else
            begin
                bit want;
                want = overlap_due.pop_front();
                if (verdict_ch.overlap !== want)
                    report_mismatch("overlap", int'(want), int'(verdict_ch.overlap));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        error_count      = 0;
        send_idle_pct    = 25;
        sink_stall_pct   = 54;
        pair_ch.valid      = 1'b0;
        pair_ch.a_center_x = '0;
        pair_ch.a_center_y = '0;
        pair_ch.a_length   = '0;
        pair_ch.a_width    = '0;
        pair_ch.a_heading  = '0;
        pair_ch.b_center_x = '0;
        pair_ch.b_center_y = '0;
        pair_ch.b_length   = '0;
        pair_ch.b_width    = '0;
        pair_ch.b_heading  = '0;

        // both points at the origin: every axis skipped
        rows[0]  = row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        // points far apart still overlap, no axis to separate them
        rows[1]  = row(-8388608, -8388608, 0, 0, 0, 8388607, 8388607, 0, 0, 0, 1);
        // largest boxes on one center
        rows[2]  = row(0, 0, 65535, 65535, 0, 0, 0, 65535, 65535, 0, 1);
        // small boxes at opposite corners of the coordinate range
        rows[3]  = row(-8388608, -8388608, 16, 16, 0, 8388607, 8388607, 16, 16, 0, 0);
        // edges exactly touching on x
        rows[4]  = row(0, 0, 512, 512, 0, 512, 0, 512, 512, 0, 1);
        // one step past touching
        rows[5]  = row(0, 0, 512, 512, 0, 513, 0, 512, 512, 0, 0);
        // zero width only, zero length only
        rows[6]  = row(0, 0, 1000, 0, 0, 0, 400, 1000, 0, 0, -1);
        rows[7]  = row(0, 0, 0, 1000, 16384, 300, 0, 0, 1000, 0, -1);
        // heading extremes and octant borders
        rows[8]  = row(0, 0, 4000, 1000, 65535, 2500, 0, 4000, 1000, 8192, -1);
        rows[9]  = row(0, 0, 4000, 1000, 8191, 0, 2500, 4000, 1000, 57344, -1);
        rows[10] = row(0, 0, 4000, 1000, 32768, 3000, 3000, 4000, 1000, 24576, -1);
        rows[11] = row(0, 0, 4000, 1000, 49152, -3000, 2000, 4000, 1000, 40960, -1);
        // rotated diamonds near contact
        rows[12] = row(100, -100, 2000, 2000, 8192, 2900, -100, 2000, 2000, 8192, -1);
        rows[13] = row(100, -100, 2000, 2000, 8192, 2800, -100, 2000, 2000, 8192, -1);
        // mixed sizes, all ones patterns in some fields
        rows[14] = row(8388607, -1, 65535, 1, 65535, -1, 8388607, 1, 65535, 65535, -1);
        rows[15] = row(-8388608, 8388607, 65535, 65535, 1, 8388607, -8388608, 65535,
                       65535, 32767, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase A: sender idles a quarter of the time, sink stalls often
        for (int i = 0; i < NUM_ROWS; i++)
            send_pair(rows[i].pair, rows[i].want);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 3)
            begin
                // phase B: swap the idle rates, after a full drain of the pipe
                pair_ch.valid <= 1'b0;
                while (overlap_due.size() != 0)
                    @(posedge clk);
                send_idle_pct  = 54;
                sink_stall_pct = 25;
            end
            else if (i == 2 * NUM_RANDOM / 3)
            begin
                // phase C: full rate on both sides
                send_idle_pct  = 0;
                sink_stall_pct = 0;
            end
            send_pair(rand_pair(), -1);
        end
        pair_ch.valid <= 1'b0;

        while (overlap_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
